>>> hw/rtl/wtmt_pkg.sv
// ----------------------------------------------------------------------------
// wtmt_pkg
// Shared types, constants and helper functions of the weighted tail
// membership tracker: request and result payloads, the update wave that
// runs down the cell chain, event codes and saturating arithmetic.
// ----------------------------------------------------------------------------
package wtmt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int WGT_W       = 37;
   localparam int FRAC_W      = 16;
   localparam int THR_W       = WGT_W + FRAC_W;

   localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};

   localparam logic CSR_LOW_TAIL  = 1'b0;
   localparam logic CSR_TAIL_FRAC = 1'b1;

   localparam logic              LOW_TAIL_RESET  = 1'b1;
   localparam logic [FRAC_W-1:0] TAIL_FRAC_RESET = 16'd6554;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_RUN,
      ST_DONE
   } wtmt_state_type;

   typedef enum logic [2:0] {
      EV_JOIN  = 3'd0,
      EV_LEAVE = 3'd1,
      EV_DONE  = 3'd2,
      EV_FULL  = 3'd3,
      EV_SKIP  = 3'd4
   } wtmt_event_type;

   typedef struct packed {
      logic signed [31:0] sample_z;
      logic [31:0]        sample_weight;
      logic               z_invalid;
   } wtmt_req_type;

   typedef struct packed {
      logic [4:0]     entry_index;
      wtmt_event_type event_kind;
      logic [5:0]     entry_count;
      logic           last;
   } wtmt_rsp_type;

   typedef struct packed {
      logic               active;
      logic [CNT_W-1:0]   remain;
      logic signed [31:0] z;
      logic [31:0]        w;
      logic               low_mode;
      logic [THR_W-1:0]   thresh;
      logic [WGT_W-1:0]   miss;
   } wtmt_wave_type;

   typedef struct packed {
      logic slot;
      logic change;
      logic leave;
      logic is_last;
   } wtmt_evt_type;

   function automatic logic [WGT_W-1:0] sat_add(input logic [WGT_W-1:0] a,
                                                 input logic [WGT_W-1:0] b);
      logic [WGT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WGT_W] ? WGT_MAX : s[WGT_W-1:0];
   endfunction

   function automatic logic in_tail(input logic [WGT_W-1:0] cum,
                                    input logic [THR_W-1:0] thresh);
      return {cum, {FRAC_W{1'b0}}} < thresh;
   endfunction

endpackage

>>> hw/rtl/wtmt_cell.sv
// ----------------------------------------------------------------------------
// wtmt_cell
// One table entry. Holds Z, weight, cumulative weight and tail flag; updates
// itself as the wave passes, writes the new entry when the wave ends here,
// and otherwise hands the wave to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module wtmt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wtmt_pkg::wtmt_wave_type wave_in,
   output wtmt_pkg::wtmt_wave_type wave_out,
   output wtmt_pkg::wtmt_evt_type  evt_out
);

   logic signed [31:0]            z_ff, z_in;
   logic [31:0]                   weight_ff, weight_in;
   logic [wtmt_pkg::WGT_W-1:0]    cum_ff, cum_in;
   logic                          flag_ff, flag_in;
   wtmt_pkg::wtmt_wave_type       fwd_ff, fwd_in;
   wtmt_pkg::wtmt_evt_type        evt_ff, evt_in;
   logic                          hit;
   logic                          member;

   always_comb begin
      hit        = wave_in.low_mode ? (z_ff > wave_in.z) : (z_ff < wave_in.z);
      z_in       = z_ff;
      weight_in  = weight_ff;
      cum_in     = cum_ff;
      flag_in    = flag_ff;
      member     = 1'b0;
      fwd_in     = wave_in;
      evt_in     = '0;
      fwd_in.active = 1'b0;
      if (wave_in.active) begin
         evt_in.slot = 1'b1;
         if (wave_in.remain == '0) begin
            // new entry lands here; the wave ends
            z_in           = wave_in.z;
            weight_in      = wave_in.w;
            cum_in         = wtmt_pkg::sat_add(wtmt_pkg::WGT_W'(wave_in.w), wave_in.miss);
            member         = wtmt_pkg::in_tail(cum_in, wave_in.thresh);
            flag_in        = member;
            evt_in.change  = member;
            evt_in.leave   = 1'b0;
            evt_in.is_last = 1'b1;
         end else begin
            if (hit) begin
               cum_in = wtmt_pkg::sat_add(cum_ff, wtmt_pkg::WGT_W'(wave_in.w));
            end else begin
               fwd_in.miss = wtmt_pkg::sat_add(wave_in.miss,
                                               wtmt_pkg::WGT_W'(weight_ff));
            end
            member        = wtmt_pkg::in_tail(cum_in, wave_in.thresh);
            flag_in       = member;
            evt_in.change = member != flag_ff;
            evt_in.leave  = flag_ff;
            fwd_in.active = 1'b1;
            fwd_in.remain = wave_in.remain - wtmt_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      z_ff      <= z_in;
      weight_ff <= weight_in;
      cum_ff    <= cum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
         fwd_ff  <= '0;
         evt_ff  <= '0;
      end else begin
         flag_ff <= flag_in;
         fwd_ff  <= fwd_in;
         evt_ff  <= evt_in;
      end
   end

   assign wave_out = fwd_ff;
   assign evt_out  = evt_ff;

endmodule

>>> hw/rtl/weighted_tail_membership_tracker.sv
// ----------------------------------------------------------------------------
// weighted_tail_membership_tracker
// Weighted sample table with tail membership events, built as a chain of
// entry cells fed by one update wave per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A skipped or refused
// request gives its single result in the next cycle and busy stays low. An
// accepted sample keeps busy high through the MULT, RUN and DONE states: the
// MULT state registers the threshold product into the wave, then the update
// wave moves one cell per clock through the chain up to the new entry. Results
// come one per cycle as single-cycle strobes on rsp_valid and must be taken
// when shown; join and leave results arrive in entry order, then done.
// ----------------------------------------------------------------------------
module weighted_tail_membership_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wtmt_pkg::wtmt_req_type req_data,
   output logic                  rsp_valid,
   output wtmt_pkg::wtmt_rsp_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int DEPTH = wtmt_pkg::TABLE_DEPTH;
   localparam int EVT_W = $bits(wtmt_pkg::wtmt_evt_type);

   wtmt_pkg::wtmt_state_type         state_ff, state_in;
   logic                             low_mode_ff;
   logic [wtmt_pkg::FRAC_W-1:0]      frac_ff;
   logic [wtmt_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [wtmt_pkg::WGT_W-1:0]       total_ff, total_in;
   logic signed [31:0]               z_ff, z_in;
   logic [31:0]                      w_ff, w_in;
   logic [wtmt_pkg::CNT_W-1:0]       remain_ff, remain_in;
   logic [wtmt_pkg::IDX_W-1:0]       idx_ff, idx_in;
   wtmt_pkg::wtmt_wave_type          wave0_ff, wave0_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   wtmt_pkg::wtmt_rsp_type           rsp_ff, rsp_in;
   logic [wtmt_pkg::THR_W-1:0]       thresh;
   logic                             accept;
   logic                             csr_write;
   logic                             table_full;

   wtmt_pkg::wtmt_wave_type          chain [DEPTH+1];
   wtmt_pkg::wtmt_evt_type           evt [DEPTH];
   logic [DEPTH-1:0]                 slot_vec;
   logic [EVT_W-1:0]                 evt_bits;
   wtmt_pkg::wtmt_evt_type           evt_any;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == wtmt_pkg::CSR_LOW_TAIL) ? {31'b0, low_mode_ff}
                                                           : {16'b0, frac_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_mode_ff <= wtmt_pkg::LOW_TAIL_RESET;
         frac_ff     <= wtmt_pkg::TAIL_FRAC_RESET;
      end else if (csr_write) begin
         if (paddr[2] == wtmt_pkg::CSR_LOW_TAIL) begin
            low_mode_ff <= pwdata[0];
         end else begin
            frac_ff <= pwdata[wtmt_pkg::FRAC_W-1:0];
         end
      end
   end

   // cell chain
   assign chain[0] = wave0_ff;

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      wtmt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wave_in  (chain[gi]),
         .wave_out (chain[gi+1]),
         .evt_out  (evt[gi])
      );
      assign slot_vec[gi] = evt[gi].slot;
   end

   always_comb begin
      evt_bits = '0;
      for (int i = 0; i < DEPTH; i++) begin
         evt_bits = evt_bits | evt[i];
      end
      evt_any = wtmt_pkg::wtmt_evt_type'(evt_bits);
   end

   assign accept     = start && !busy;
   assign table_full = count_ff >= wtmt_pkg::CNT_W'(DEPTH);
   assign thresh     = wtmt_pkg::THR_W'(total_ff) * wtmt_pkg::THR_W'(frac_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wtmt_pkg::ST_IDLE: begin
            if (accept && !req_data.z_invalid && !table_full) begin
               state_in = wtmt_pkg::ST_MULT;
            end
         end
         wtmt_pkg::ST_MULT: begin
            state_in = wtmt_pkg::ST_RUN;
         end
         wtmt_pkg::ST_RUN: begin
            if (evt_any.slot && evt_any.is_last) begin
               state_in = wtmt_pkg::ST_DONE;
            end
         end
         wtmt_pkg::ST_DONE: begin
            state_in = wtmt_pkg::ST_IDLE;
         end
         default: begin
            state_in = wtmt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      busy         = state_ff != wtmt_pkg::ST_IDLE;
      count_in     = count_ff;
      total_in     = total_ff;
      z_in         = z_ff;
      w_in         = w_ff;
      remain_in    = remain_ff;
      idx_in       = idx_ff;
      wave0_in     = '0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         wtmt_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.entry_index = '0;
               rsp_in.entry_count = 6'(count_ff);
               rsp_in.last        = 1'b1;
               if (req_data.z_invalid) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.event_kind = wtmt_pkg::EV_SKIP;
               end else if (table_full) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.event_kind = wtmt_pkg::EV_FULL;
               end else begin
                  total_in  = wtmt_pkg::sat_add(total_ff,
                                                wtmt_pkg::WGT_W'(req_data.sample_weight));
                  count_in  = count_ff + wtmt_pkg::CNT_W'(1);
                  remain_in = count_ff;
                  z_in      = req_data.sample_z;
                  w_in      = req_data.sample_weight;
                  idx_in    = '0;
               end
            end
         end
         wtmt_pkg::ST_MULT: begin
            wave0_in.active   = 1'b1;
            wave0_in.remain   = remain_ff;
            wave0_in.z        = z_ff;
            wave0_in.w        = w_ff;
            wave0_in.low_mode = low_mode_ff;
            wave0_in.thresh   = thresh;
            wave0_in.miss     = '0;
         end
         wtmt_pkg::ST_RUN: begin
            if (evt_any.slot) begin
               idx_in = idx_ff + wtmt_pkg::IDX_W'(1);
               if (evt_any.change) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.entry_index = 5'(idx_ff);
                  rsp_in.event_kind  = evt_any.leave ? wtmt_pkg::EV_LEAVE
                                                     : wtmt_pkg::EV_JOIN;
                  rsp_in.entry_count = 6'(count_ff);
                  rsp_in.last        = 1'b0;
               end
            end
         end
         wtmt_pkg::ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.entry_index = '0;
            rsp_in.event_kind  = wtmt_pkg::EV_DONE;
            rsp_in.entry_count = 6'(count_ff);
            rsp_in.last        = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wtmt_pkg::ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         wave0_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         wave0_ff     <= wave0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff      <= z_in;
      w_ff      <= w_in;
      remain_ff <= remain_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(slot_vec))
      else $error("more than one cell active");

   a_wave_ends: assert property (@(posedge clock) disable iff (reset)
      !chain[DEPTH].active)
      else $error("update wave ran off the end of the chain");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind == wtmt_pkg::EV_DONE |-> !busy)
      else $error("done result while still busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wtmt_pkg::CNT_W'(DEPTH))
      else $error("entry count beyond table depth");

endmodule
